[hdl/prim_minimum_spanning_tree_defines.svh]
`ifndef PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PMST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prim mst check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PMST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prim mst check failed");

`endif

[hdl/prim_mst_pkg.sv]
`timescale 1ns / 1ps

package prim_mst_pkg;

    localparam int VTX_BITS       = 4;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int EDGE_BITS      = 16;
    localparam int COST_BITS      = 20;
    localparam int COUNT_BITS     = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_START = 1'b1;

endpackage

[hdl/prim_minimum_spanning_tree.sv]
`timescale 1ns / 1ps
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+-------------------------------------
// in       | sink      | in_valid / in_ready          | action, row_index, col_index, weight
// out      | source    | out_valid / out_ready        | vertex, parent_vertex, edge_weight,
//          |           |                              | total_cost, last
// cfg      | sink      | cfg_write_en, cfg_write_data | vertex_count
//
// A start transaction runs n key-scan passes through the shared compare/update unit and
// the two-port weight memory read, then emits n-1 results.
// in_ready is high only while idle; a held result does not block the next transaction.
// rst_n clears control state asynchronously; the weight memory has no reset.
// out_ready low freezes the emit sequence with the result held.

module prim_minimum_spanning_tree
    import prim_mst_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [COUNT_BITS-1:0]     cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      action,
    input  logic [VTX_BITS-1:0]       row_index,
    input  logic [VTX_BITS-1:0]       col_index,
    input  logic [IN_WEIGHT_BITS-1:0] weight,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [VTX_BITS-1:0]       vertex,
    output logic [VTX_BITS-1:0]       parent_vertex,
    output logic [EDGE_BITS-1:0]      edge_weight,
    output logic [COST_BITS-1:0]      total_cost,
    output logic                      last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int KW = WEIGHT_BITS + 1;
    localparam logic [KW-1:0] KEY_INF = '1;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN     = 4'b0010,
        ST_EMIT_RD  = 4'b0100,
        ST_EMIT_OUT = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_BITS-1:0]   vertex_count_reg;
    logic [CW-1:0]           n_reg, n_next, n_eff;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [VW-1:0]           cnt_idx;
    logic                    pvalid_reg, pvalid_next;
    logic [VW-1:0]           pv_reg, pv_next;
    logic [VW-1:0]           u_reg, u_next;
    logic [MAX_VERTICES-1:0] in_tree_reg, in_tree_next;
    logic [MAX_VERTICES-1:0] touched_reg, touched_next;
    logic                    found_reg, found_next;
    logic [VW-1:0]           best_v_reg, best_v_next;
    logic [KW-1:0]           best_key_reg, best_key_next;
    logic [COST_BITS-1:0]    sum_reg, sum_next;

    logic                    out_valid_reg, out_valid_next;
    logic [VTX_BITS-1:0]     vertex_reg, vertex_next;
    logic [VTX_BITS-1:0]     parent_reg, parent_next;
    logic [EDGE_BITS-1:0]    edge_reg, edge_next;
    logic [COST_BITS-1:0]    total_reg, total_next;
    logic                    last_reg, last_next;

    logic [WEIGHT_BITS-1:0]  weight_mem [MAX_VERTICES*MAX_VERTICES];
    logic [WEIGHT_BITS-1:0]  wt_a_reg, wt_b_reg;
    logic [KW-1:0]           key_mem [MAX_VERTICES];
    logic [VW-1:0]           parent_mem [MAX_VERTICES];
    logic [KW-1:0]           key_rd_reg;
    logic [VW-1:0]           parent_rd_reg;

    logic                    in_accept;
    logic                    load_we;
    logic [AW-1:0]           load_addr;
    logic [AW-1:0]           rd_addr_a, rd_addr_b;
    logic [WEIGHT_BITS-1:0]  w_min;
    logic [KW-1:0]           cur_key, new_key, eff_key;
    logic                    cand, upd, take, found_now, pass_end, fin;
    logic [VW-1:0]           best_now;
    logic [COST_BITS-1:0]    sum_new;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_accept     = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign vertex        = vertex_reg;
    assign parent_vertex = parent_reg;
    assign edge_weight   = edge_reg;
    assign total_cost    = total_reg;
    assign last          = last_reg;

    // effective vertex count, clamped to [2, MAX_VERTICES]
    always_comb
    begin
        if (vertex_count_reg < COUNT_BITS'(2))
            n_eff = CW'(2);
        else if (int'(vertex_count_reg) > MAX_VERTICES)
            n_eff = CW'(MAX_VERTICES);
        else
            n_eff = CW'(vertex_count_reg);
    end

    assign load_we   = in_accept && (action == ACT_LOAD)
                       && (int'(row_index) < MAX_VERTICES)
                       && (int'(col_index) < MAX_VERTICES);
    assign load_addr = AW'(int'(VW'(row_index)) * MAX_VERTICES + int'(VW'(col_index)));

    assign cnt_idx   = cnt_reg[VW-1:0];
    assign rd_addr_a = AW'(int'(u_reg) * MAX_VERTICES + int'(cnt_idx));
    assign rd_addr_b = AW'(int'(cnt_idx) * MAX_VERTICES + int'(u_reg));

    // shared compare/update unit, one vertex per cycle within a key-scan pass
    always_comb
    begin
        w_min     = (wt_a_reg < wt_b_reg) ? wt_a_reg : wt_b_reg;
        cur_key   = touched_reg[pv_reg] ? key_rd_reg : KEY_INF;
        new_key   = {1'b0, w_min};
        cand      = pvalid_reg && !in_tree_reg[pv_reg];
        upd       = cand && (new_key < cur_key);
        eff_key   = upd ? new_key : cur_key;
        take      = cand && (!found_reg || (eff_key < best_key_reg));
        found_now = found_reg || take;
        best_now  = take ? pv_reg : best_v_reg;
        pass_end  = pvalid_reg && (CW'(pv_reg) == n_reg - CW'(1));
        fin       = (cnt_reg == n_reg - CW'(1));
        sum_new   = sum_reg + COST_BITS'(key_rd_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        pvalid_next    = pvalid_reg;
        pv_next        = pv_reg;
        u_next         = u_reg;
        in_tree_next   = in_tree_reg;
        touched_next   = touched_reg;
        found_next     = found_reg;
        best_v_next    = best_v_reg;
        best_key_next  = best_key_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        vertex_next    = vertex_reg;
        parent_next    = parent_reg;
        edge_next      = edge_reg;
        total_next     = total_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (action == ACT_START))
                begin
                    n_next          = n_eff;
                    in_tree_next    = '0;
                    in_tree_next[0] = 1'b1;
                    touched_next    = '0;
                    u_next          = '0;
                    cnt_next        = '0;
                    pvalid_next     = 1'b0;
                    found_next      = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < n_reg)
                begin
                    cnt_next    = cnt_reg + CW'(1);
                    pvalid_next = 1'b1;
                    pv_next     = cnt_idx;
                end
                else
                    pvalid_next = 1'b0;
                if (upd)
                    touched_next[pv_reg] = 1'b1;
                if (take)
                begin
                    found_next    = 1'b1;
                    best_v_next   = pv_reg;
                    best_key_next = eff_key;
                end
                if (pass_end)
                begin
                    found_next = 1'b0;
                    if (found_now)
                    begin
                        u_next                 = best_now;
                        in_tree_next[best_now] = 1'b1;
                        cnt_next               = '0;
                    end
                    else
                    begin
                        cnt_next   = CW'(1);
                        sum_next   = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vertex_next    = VTX_BITS'(cnt_reg);
                    parent_next    = VTX_BITS'(parent_rd_reg);
                    edge_next      = EDGE_BITS'(key_rd_reg);
                    total_next     = fin ? sum_new : '0;
                    last_next      = fin;
                    sum_next       = sum_new;
                    cnt_next       = cnt_reg + CW'(1);
                    state_next     = fin ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= COUNT_RESET;
            n_reg            <= CW'(2);
            cnt_reg          <= '0;
            pvalid_reg       <= 1'b0;
            pv_reg           <= '0;
            u_reg            <= '0;
            in_tree_reg      <= '0;
            touched_reg      <= '0;
            found_reg        <= 1'b0;
            best_v_reg       <= '0;
            best_key_reg     <= KEY_INF;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_en)
                vertex_count_reg <= cfg_write_data;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            pvalid_reg    <= pvalid_next;
            pv_reg        <= pv_next;
            u_reg         <= u_next;
            in_tree_reg   <= in_tree_next;
            touched_reg   <= touched_next;
            found_reg     <= found_next;
            best_v_reg    <= best_v_next;
            best_key_reg  <= best_key_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vertex_reg <= vertex_next;
        parent_reg <= parent_next;
        edge_reg   <= edge_next;
        total_reg  <= total_next;
        last_reg   <= last_next;
    end

    // weight matrix: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (load_we)
            weight_mem[load_addr] <= WEIGHT_BITS'(weight);
        wt_a_reg <= weight_mem[rd_addr_a];
        wt_b_reg <= weight_mem[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            key_mem[pv_reg]    <= new_key;
            parent_mem[pv_reg] <= u_reg;
        end
        key_rd_reg    <= key_mem[cnt_idx];
        parent_rd_reg <= parent_mem[cnt_idx];
    end

endmodule

[hdl/prim_mst_checker.sv]
`timescale 1ns / 1ps
`include "prim_minimum_spanning_tree_defines.svh"

module prim_mst_checker
    import prim_mst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  action,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [VTX_BITS-1:0]   vertex,
    input logic [VTX_BITS-1:0]   parent_vertex,
    input logic [EDGE_BITS-1:0]  edge_weight,
    input logic [COST_BITS-1:0]  total_cost,
    input logic                  last
);

    `PMST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vertex) && $stable(parent_vertex) && $stable(edge_weight) && $stable(total_cost) && $stable(last))
    `PMST_ASSERT_NEXT(a_start_busy, in_valid && in_ready && (action == ACT_START), !in_ready)
    `PMST_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (action == ACT_LOAD) && !out_valid, !out_valid)
    `PMST_ASSERT_SAME(a_cost_on_last, out_valid && !last, total_cost == '0)

endmodule

bind prim_minimum_spanning_tree prim_mst_checker u_prim_mst_checker (.*);

[verif/prim_minimum_spanning_tree_test.sv]
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_test;
    import prim_mst_pkg::*;

    localparam int VTX_SLOTS = 1 << VTX_BITS;
    localparam logic [EDGE_BITS:0] KEY_INFINITY = '1;
    localparam int ITEM_TARGET = 450;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES = 350;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                      act;
        logic [VTX_BITS-1:0]       row;
        logic [VTX_BITS-1:0]       col;
        logic [IN_WEIGHT_BITS-1:0] w;
    } mst_item_t;

    typedef struct packed {
        logic [VTX_BITS-1:0]  vertex;
        logic [VTX_BITS-1:0]  parent;
        logic [EDGE_BITS-1:0] edge_weight;
        logic [COST_BITS-1:0] total_cost;
        logic                 last;
    } tree_link_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [COUNT_BITS-1:0]     cfg_write_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      action = ACT_LOAD;
    logic [VTX_BITS-1:0]       row_index = '0;
    logic [VTX_BITS-1:0]       col_index = '0;
    logic [IN_WEIGHT_BITS-1:0] weight = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [VTX_BITS-1:0]       vertex;
    logic [VTX_BITS-1:0]       parent_vertex;
    logic [EDGE_BITS-1:0]      edge_weight;
    logic [COST_BITS-1:0]      total_cost;
    logic                      last;

    mst_item_t  pending_q[$];
    tree_link_t tree_links_q[$];

    logic [EDGE_BITS-1:0]   weight_mem [VTX_SLOTS][VTX_SLOTS];
    logic [COUNT_BITS-1:0]  vertex_limit = COUNT_RESET;
    bit                     filled [VTX_SLOTS][VTX_SLOTS];
    int unsigned            gen_count = 32'(COUNT_RESET);

    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    int unsigned in_wait = 0;
    int unsigned out_stall = 0;
    int unsigned in_gap_max = 16;
    int unsigned out_gap_max = 16;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned item_total = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    prim_minimum_spanning_tree uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .row_index      (row_index),
        .col_index      (col_index),
        .weight         (weight),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .vertex         (vertex),
        .parent_vertex  (parent_vertex),
        .edge_weight    (edge_weight),
        .total_cost     (total_cost),
        .last           (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned effective_count(int unsigned cnt);
        if (cnt < 2)
            return 2;
        if (cnt > VTX_SLOTS)
            return VTX_SLOTS;
        return cnt;
    endfunction

    // Prim from vertex 0 with a linear key scan; ties go to the lower index.
    function automatic void predict_tree(int unsigned cnt);
        int unsigned          n;
        int unsigned          u;
        logic [EDGE_BITS:0]   key [VTX_SLOTS];
        logic [VTX_BITS-1:0]  par [VTX_SLOTS];
        bit                   done [VTX_SLOTS];
        logic [EDGE_BITS-1:0] w;
        logic [COST_BITS-1:0] sum;
        tree_link_t           link;
        n = effective_count(cnt);
        for (int i = 0; i < VTX_SLOTS; i++)
        begin
            key[i] = KEY_INFINITY;
            par[i] = '0;
            done[i] = 1'b0;
        end
        key[0] = '0;
        for (int step = 0; step < n; step++)
        begin
            u = n;
            for (int i = 0; i < n; i++)
            begin
                if (!done[i] && (u == n || key[i] < key[u]))
                    u = i;
            end
            if (u >= n)
                break;
            done[u] = 1'b1;
            for (int v = 0; v < n; v++)
            begin
                if (!done[v])
                begin
                    w = (weight_mem[u][v] < weight_mem[v][u]) ? weight_mem[u][v]
                                                              : weight_mem[v][u];
                    if ({1'b0, w} < key[v])
                    begin
                        key[v] = {1'b0, w};
                        par[v] = u[VTX_BITS-1:0];
                    end
                end
            end
        end
        sum = '0;
        for (int i = 0; i < n; i++)
            sum = sum + COST_BITS'(key[i]);
        for (int v = 1; v < n; v++)
        begin
            link.vertex = v[VTX_BITS-1:0];
            link.parent = par[v];
            link.edge_weight = key[v][EDGE_BITS-1:0];
            link.total_cost = (v == n - 1) ? sum : '0;
            link.last = (v == n - 1);
            tree_links_q.push_back(link);
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // input side: config tracking, weight loads and a prediction per accepted start transaction
    always @(posedge clk)
    begin : in_track
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && cfg_write_en)
            vertex_limit = cfg_write_data;
        if (rst_n && in_valid && in_ready)
        begin
            if (action == ACT_LOAD)
                weight_mem[row_index][col_index] = weight;
            else
                predict_tree(32'(vertex_limit));
        end
    end

    always @(posedge clk)
    begin : out_check
        tree_link_t want;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (tree_links_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result for vertex %0d", vertex));
            end
            else
            begin
                want = tree_links_q.pop_front();
                if (vertex !== want.vertex)
                    report_mismatch($sformatf("vertex %0d, want %0d", vertex, want.vertex));
                if (parent_vertex !== want.parent)
                    report_mismatch($sformatf("vertex %0d parent %0d, want %0d",
                                              want.vertex, parent_vertex, want.parent));
                if (edge_weight !== want.edge_weight)
                    report_mismatch($sformatf("vertex %0d edge_weight %0d, want %0d",
                                              want.vertex, edge_weight, want.edge_weight));
                if (total_cost !== want.total_cost)
                    report_mismatch($sformatf("vertex %0d total_cost %0d, want %0d",
                                              want.vertex, total_cost, want.total_cost));
                if (last !== want.last)
                    report_mismatch($sformatf("vertex %0d last %0d, want %0d",
                                              want.vertex, last, want.last));
            end
        end
    end

    always @(negedge clk)
    begin : driver
        mst_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait = 0;
        end
        else if (in_valid && !in_fire)
        begin
            in_valid <= 1'b1;
        end
        else if (in_wait > 0)
        begin
            in_valid <= 1'b0;
            in_wait--;
        end
        else if (pending_q.size() != 0)
        begin
            item = pending_q.pop_front();
            action <= item.act;
            row_index <= item.row;
            col_index <= item.col;
            weight <= item.w;
            in_valid <= 1'b1;
            in_wait = $urandom_range(0, in_gap_max);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= (hold_left == 0);
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (out_fire)
        begin
            out_stall = $urandom_range(0, out_gap_max);
            out_ready <= (out_stall == 0);
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= (out_stall == 0);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("prim_minimum_spanning_tree_test: done, errors");
            $finish;
        end
    end

    function automatic logic [IN_WEIGHT_BITS-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return IN_WEIGHT_BITS'($urandom_range(0, 3));
            default: return IN_WEIGHT_BITS'($urandom_range(0, (1 << IN_WEIGHT_BITS) - 1));
        endcase
    endfunction

    task automatic queue_load(int unsigned r, int unsigned c, logic [IN_WEIGHT_BITS-1:0] w);
        mst_item_t item;
        item.act = ACT_LOAD;
        item.row = r[VTX_BITS-1:0];
        item.col = c[VTX_BITS-1:0];
        item.w = w;
        pending_q.push_back(item);
        filled[r][c] = 1'b1;
        item_total++;
    endtask

    // off-diagonal entries that the run will read and that were never loaded get loaded first
    task automatic queue_start();
        int unsigned n;
        mst_item_t   item;
        n = effective_count(gen_count);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                if (r != c && !filled[r][c])
                    queue_load(r, c, rand_weight());
            end
        end
        item.act = ACT_START;
        item.row = VTX_BITS'($urandom_range(0, VTX_SLOTS - 1));
        item.col = VTX_BITS'($urandom_range(0, VTX_SLOTS - 1));
        item.w = IN_WEIGHT_BITS'($urandom_range(0, (1 << IN_WEIGHT_BITS) - 1));
        pending_q.push_back(item);
        item_total++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || tree_links_q.size() != 0);
    endtask

    task automatic set_vertex_count(int unsigned cnt);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= cnt[COUNT_BITS-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
        gen_count = cnt;
    endtask

    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 16;
        endcase
    endfunction

    initial
    begin
        int unsigned pick;
        int unsigned cnt;
        for (int r = 0; r < VTX_SLOTS; r++)
            for (int c = 0; c < VTX_SLOTS; c++)
                filled[r][c] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero weight and asymmetric entries, then max weights
        set_vertex_count(2);
        queue_load(0, 1, '0);
        queue_load(1, 0, '1);
        queue_start();
        queue_load(0, 1, '1);
        queue_load(1, 0, '1);
        queue_load(15, 15, '0);
        queue_start();

        // all-equal weights: ties go to the lower index
        set_vertex_count(3);
        queue_load(0, 1, IN_WEIGHT_BITS'(5));
        queue_load(1, 0, IN_WEIGHT_BITS'(5));
        queue_load(0, 2, IN_WEIGHT_BITS'(5));
        queue_load(2, 0, IN_WEIGHT_BITS'(5));
        queue_load(1, 2, IN_WEIGHT_BITS'(5));
        queue_load(2, 1, IN_WEIGHT_BITS'(5));
        queue_start();

        // counts below range clamp to two
        set_vertex_count(0);
        queue_start();
        set_vertex_count(1);
        queue_start();

        // output held off long enough to stall the input
        set_vertex_count(4);
        in_gap_max = 0;
        out_gap_max = 0;
        hold_request = 1'b1;
        queue_start();
        repeat (4)
            queue_load($urandom_range(0, 3), $urandom_range(0, 3), rand_weight());
        queue_start();
        wait_drained();
        queue_start();

        while (item_total < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 11)
                cnt = $urandom_range(2, 5);
            else if (pick < 16)
                cnt = $urandom_range(6, 15);
            else if (pick < 18)
                cnt = $urandom_range(16, 31);
            else
                cnt = $urandom_range(0, 1);
            set_vertex_count(cnt);
            in_gap_max = pick_gap();
            out_gap_max = pick_gap();
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(0, 6))
                    queue_load($urandom_range(0, VTX_SLOTS - 1),
                               $urandom_range(0, VTX_SLOTS - 1), rand_weight());
                queue_start();
            end
        end

        set_vertex_count(VTX_SLOTS);
        queue_start();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("prim_minimum_spanning_tree_test: done, clean");
        else
            $display("prim_minimum_spanning_tree_test: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/prim_mst_pkg.sv
hdl/prim_minimum_spanning_tree.sv
hdl/prim_mst_checker.sv
verif/prim_minimum_spanning_tree_test.sv
